// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

	localparam int HUE_W    = 15;
	localparam int SAT_W    = 9;
	localparam int VAL_W    = 8;
	localparam int COL_W    = 8;
	localparam int FRAC_W   = 12;
	localparam int REM_W    = 12;
	localparam int SECTOR_W = 3;
	localparam int PROD_W   = SAT_W + FRAC_W;

	localparam logic [HUE_W-1:0]  HUE_FULL_TURN = 15'd23040;
	localparam logic [HUE_W-1:0]  HUE_SECTOR    = 15'd3840;
	localparam logic [SAT_W-1:0]  SAT_ONE       = 9'd256;
	localparam logic [FRAC_W:0]   FRAC_ONE      = 13'd4096;
	localparam logic [PROD_W-1:0] PROD_ONE      = PROD_W'(1) << (PROD_W - 1);

	// ceil(2^19 / 15): rem * 16 / 15 becomes (rem * RECIP_15) >> 15, exact for rem < 3840
	localparam int              RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] RECIP_15 = 16'd34953;
	localparam int              RECIP_SHIFT = 15;

	localparam int QUEUE_DEPTH = 2;

	// hue sectors of 60 degrees each
	localparam logic [SECTOR_W-1:0] SECT_RED     = 3'd0;
	localparam logic [SECTOR_W-1:0] SECT_YELLOW  = 3'd1;
	localparam logic [SECTOR_W-1:0] SECT_GREEN   = 3'd2;
	localparam logic [SECTOR_W-1:0] SECT_CYAN    = 3'd3;
	localparam logic [SECTOR_W-1:0] SECT_BLUE    = 3'd4;
	localparam logic [SECTOR_W-1:0] SECT_MAGENTA = 3'd5;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [FRAC_W-1:0]   frac;
		logic [SAT_W-1:0]    sat;
		logic [VAL_W-1:0]    val;
	} job_t;

endpackage

// ===== rtl/hsv2rgb_if.sv =====
interface hsv2rgb_hsv_if
	import hsv2rgb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [VAL_W-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if
	import hsv2rgb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] red;
	logic [COL_W-1:0] green;
	logic [COL_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hsv2rgb_front.sv =====
module hsv2rgb_front
	import hsv2rgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hsv2rgb_hsv_if.sink hsv_in,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	localparam logic [HUE_W-1:0] BASE_1 = HUE_SECTOR;
	localparam logic [HUE_W-1:0] BASE_2 = HUE_W'(2 * HUE_SECTOR);
	localparam logic [HUE_W-1:0] BASE_3 = HUE_W'(3 * HUE_SECTOR);
	localparam logic [HUE_W-1:0] BASE_4 = HUE_W'(4 * HUE_SECTOR);
	localparam logic [HUE_W-1:0] BASE_5 = HUE_W'(5 * HUE_SECTOR);

	logic                  valid_s1;
	logic [SECTOR_W-1:0]   sector_s1;
	logic [REM_W-1:0]      rem_s1;
	logic [SAT_W-1:0]      sat_s1;
	logic [VAL_W-1:0]      val_s1;
	logic                  valid_s2;
	job_t                  job_s2;

	logic [HUE_W-1:0]      hue_c;
	logic [HUE_W-1:0]      base_c;
	logic [SECTOR_W-1:0]   sector_c;
	logic [SAT_W-1:0]      sat_c;
	logic [REM_W+RECIP_W-1:0] frac_prod;
	logic                  ready_s1;
	logic                  adv_s2;

	assign hue_c = (hsv_in.hue >= HUE_FULL_TURN) ? '0 : hsv_in.hue;
	assign sat_c = (hsv_in.saturation > SAT_ONE) ? SAT_ONE : hsv_in.saturation;

	always_comb begin
		if (hue_c >= BASE_5) begin
			sector_c = SECT_MAGENTA;
			base_c   = BASE_5;
		end else if (hue_c >= BASE_4) begin
			sector_c = SECT_BLUE;
			base_c   = BASE_4;
		end else if (hue_c >= BASE_3) begin
			sector_c = SECT_CYAN;
			base_c   = BASE_3;
		end else if (hue_c >= BASE_2) begin
			sector_c = SECT_GREEN;
			base_c   = BASE_2;
		end else if (hue_c >= BASE_1) begin
			sector_c = SECT_YELLOW;
			base_c   = BASE_1;
		end else begin
			sector_c = SECT_RED;
			base_c   = '0;
		end
	end

	assign adv_s2   = valid_s1 && (!valid_s2 || job_ready);
	assign ready_s1 = !valid_s1 || adv_s2;
	assign hsv_in.ready = ready_s1;

	// fraction of the sector with 12 fraction bits: rem * 4096 / 3840
	assign frac_prod = (REM_W+RECIP_W)'(rem_s1) * (REM_W+RECIP_W)'(RECIP_15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= hsv_in.valid;
			if (!valid_s2 || job_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (hsv_in.valid && ready_s1) begin
			sector_s1 <= sector_c;
			rem_s1    <= REM_W'(hue_c - base_c);
			sat_s1    <= sat_c;
			val_s1    <= hsv_in.brightness;
		end
		if (adv_s2) begin
			job_s2.sector <= sector_s1;
			job_s2.frac   <= frac_prod[RECIP_SHIFT +: FRAC_W];
			job_s2.sat    <= sat_s1;
			job_s2.val    <= val_s1;
		end
	end

	assign job_valid = valid_s2;
	assign job       = job_s2;

endmodule

// ===== rtl/hsv2rgb_queue.sv =====
module hsv2rgb_queue
	import hsv2rgb_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output job_t out_job
);

	localparam int PTR_W = $clog2(Depth);
	localparam int CNT_W = $clog2(Depth + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Depth - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Depth);

	job_t             mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != CNT_FULL;
	assign out_valid = count_q != '0;
	assign out_job   = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_job;
	end

endmodule

// ===== rtl/hsv2rgb_back.sv =====
module hsv2rgb_back
	import hsv2rgb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  job_t          job,
	hsv2rgb_rgb_if.source rgb_out
);

	localparam int PV_W = VAL_W + SAT_W;
	localparam int QV_W = VAL_W + PROD_W;

	logic                valid_s1;
	logic [PROD_W-1:0]   qk_s1;
	logic [PROD_W-1:0]   tk_s1;
	logic [COL_W-1:0]    p_s1;
	logic [VAL_W-1:0]    val_s1;
	logic [SECTOR_W-1:0] sector_s1;
	logic                valid_s2;
	logic [COL_W-1:0]    red_s2;
	logic [COL_W-1:0]    green_s2;
	logic [COL_W-1:0]    blue_s2;

	logic [PROD_W-1:0]   sf;
	logic [PROD_W-1:0]   st;
	logic [PV_W-1:0]     p_prod;
	logic [QV_W-1:0]     q_prod;
	logic [QV_W-1:0]     t_prod;
	logic [COL_W-1:0]    q_c;
	logic [COL_W-1:0]    t_c;
	logic [COL_W-1:0]    v_c;
	logic                adv_s2;

	// s*f and s*(1-f) with 20 fraction bits, v*(1-s) with 8
	assign sf     = PROD_W'(job.sat) * PROD_W'(job.frac);
	assign st     = PROD_W'(job.sat) * PROD_W'(FRAC_ONE - {1'b0, job.frac});
	assign p_prod = PV_W'(job.val) * PV_W'(SAT_ONE - job.sat);

	assign q_prod = QV_W'(val_s1) * QV_W'(qk_s1);
	assign t_prod = QV_W'(val_s1) * QV_W'(tk_s1);
	assign q_c    = q_prod[PROD_W-1 +: COL_W];
	assign t_c    = t_prod[PROD_W-1 +: COL_W];
	assign v_c    = COL_W'(val_s1);

	assign adv_s2    = valid_s1 && (!valid_s2 || rgb_out.ready);
	assign job_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (job_ready)
				valid_s1 <= job_valid;
			if (!valid_s2 || rgb_out.ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			qk_s1     <= PROD_ONE - sf;
			tk_s1     <= PROD_ONE - st;
			p_s1      <= p_prod[SAT_W-1 +: COL_W];
			val_s1    <= job.val;
			sector_s1 <= job.sector;
		end
		if (adv_s2) begin
			case (sector_s1)
				SECT_RED: begin
					red_s2 <= v_c; green_s2 <= t_c; blue_s2 <= p_s1;
				end
				SECT_YELLOW: begin
					red_s2 <= q_c; green_s2 <= v_c; blue_s2 <= p_s1;
				end
				SECT_GREEN: begin
					red_s2 <= p_s1; green_s2 <= v_c; blue_s2 <= t_c;
				end
				SECT_CYAN: begin
					red_s2 <= p_s1; green_s2 <= q_c; blue_s2 <= v_c;
				end
				SECT_BLUE: begin
					red_s2 <= t_c; green_s2 <= p_s1; blue_s2 <= v_c;
				end
				default: begin
					red_s2 <= v_c; green_s2 <= p_s1; blue_s2 <= q_c;
				end
			endcase
		end
	end

	assign rgb_out.valid = valid_s2;
	assign rgb_out.red   = red_s2;
	assign rgb_out.green = green_s2;
	assign rgb_out.blue  = blue_s2;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// hsv to 8-bit rgb conversion, one colour per word. a new word is taken every clock cycle
// while the output side keeps up; each accepted word passes the front-end stages, the queue
// and the back-end stages. the front end clamps hue and saturation and finds the sector
// and its fraction (two stages, one multiply by a reciprocal of 15), a short queue of
// QueueDepth words follows, and the back end forms p, q and t and routes them by sector
// (two stages, the multipliers set the critical path). when the output stalls, the queue and
// both pipelines fill before input ready drops, so up to QueueDepth + 4 words are in flight.
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	hsv2rgb_hsv_if.sink   hsv_in,
	hsv2rgb_rgb_if.source rgb_out
);

	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic back_valid;
	logic back_ready;
	job_t back_job;

	hsv2rgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_in    (hsv_in),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	hsv2rgb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_job    (front_job),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_job   (back_job)
	);

	hsv2rgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.job       (back_job),
		.rgb_out   (rgb_out)
	);

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
module hsv2rgb_checker
	import hsv2rgb_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [COL_W-1:0] red,
	input logic [COL_W-1:0] green,
	input logic [COL_W-1:0] blue
);

	localparam int CAPACITY = QueueDepth + 4;
	localparam int CNT_W    = $clog2(CAPACITY + 2);
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted whose result has not yet been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
		&& $stable(blue))
		else $error("stalled result changed or dropped");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a pending input word");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_CAP)
		else $error("more words in flight than the pipeline holds");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker #(
	.QueueDepth (QueueDepth)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsv_in.valid),
	.in_ready  (hsv_in.ready),
	.out_valid (rgb_out.valid),
	.out_ready (rgb_out.ready),
	.red       (rgb_out.red),
	.green     (rgb_out.green),
	.blue      (rgb_out.blue)
);

// ===== tb/sv/hsv_to_rgb_checker.sv =====
module hsv_to_rgb_checker
	import hsv2rgb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hsv_valid,
	input  logic             hsv_ready,
	input  logic [HUE_W-1:0] hue,
	input  logic [SAT_W-1:0] saturation,
	input  logic [VAL_W-1:0] brightness,
	input  logic             rgb_valid,
	input  logic             rgb_ready,
	input  logic [COL_W-1:0] red,
	input  logic [COL_W-1:0] green,
	input  logic [COL_W-1:0] blue,
	output int               mismatches,
	output int               waiting,
	output int               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} rgb_word_t;

	rgb_word_t expected_rgb[$];
	rgb_word_t want_word;

	function automatic rgb_word_t hsv_to_rgb_colour(input logic [HUE_W-1:0] h_in,
			input logic [SAT_W-1:0] s_in, input logic [VAL_W-1:0] v_in);
		int unsigned h, s, v, f, p, q, t, one_s, one_f;
		logic [SECTOR_W-1:0] sector;
		rgb_word_t c;
		one_s = 32'(SAT_ONE);
		one_f = 32'(FRAC_ONE);
		h = (h_in >= HUE_FULL_TURN) ? 32'd0 : 32'(h_in);
		s = (s_in > SAT_ONE) ? one_s : 32'(s_in);
		v = 32'(v_in);
		sector = SECTOR_W'(h / HUE_SECTOR);
		f = ((h % HUE_SECTOR) * one_f) / HUE_SECTOR;
		p = (v * (one_s - s)) >> 8;
		q = (v * (one_s * one_f - s * f)) >> (FRAC_W + 8);
		t = (v * (one_s * one_f - s * (one_f - f))) >> (FRAC_W + 8);
		case (sector)
			SECT_RED: begin
				c = '{red: COL_W'(v), green: COL_W'(t), blue: COL_W'(p)};
			end
			SECT_YELLOW: begin
				c = '{red: COL_W'(q), green: COL_W'(v), blue: COL_W'(p)};
			end
			SECT_GREEN: begin
				c = '{red: COL_W'(p), green: COL_W'(v), blue: COL_W'(t)};
			end
			SECT_CYAN: begin
				c = '{red: COL_W'(p), green: COL_W'(q), blue: COL_W'(v)};
			end
			SECT_BLUE: begin
				c = '{red: COL_W'(t), green: COL_W'(p), blue: COL_W'(v)};
			end
			// magenta, and anything out of range
			default: begin
				c = '{red: COL_W'(v), green: COL_W'(p), blue: COL_W'(q)};
			end
		endcase
		return c;
	endfunction

	task automatic check_field(input string name, input logic [COL_W-1:0] want,
			input logic [COL_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s wrong in rgb word %0d: expected %0d, actual %0d",
				$time, name, checked, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		waiting = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_rgb.delete();
		end else begin
			if (hsv_valid && hsv_ready)
				expected_rgb.push_back(hsv_to_rgb_colour(hue, saturation, brightness));
			if (rgb_valid && rgb_ready) begin
				if (expected_rgb.size() == 0) begin
					$display("%0t ns: unexpected rgb word: expected nothing, actual %0d/%0d/%0d",
						$time, red, green, blue);
					mismatches++;
				end else begin
					want_word = expected_rgb.pop_front();
					check_field("red", want_word.red, red);
					check_field("green", want_word.green, green);
					check_field("blue", want_word.blue, blue);
					checked++;
				end
			end
		end
		waiting = expected_rgb.size();
	end

endmodule

// ===== tb/sv/hsv_to_rgb_converter_tb.sv =====
module hsv_to_rgb_converter_tb;
	import hsv2rgb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1100;
	localparam int CALM_WORDS   = 300;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	bit src_idle_en  = 1'b1;
	bit sink_idle_en = 1'b1;
	bit hold_off     = 1'b0;
	int words_sent   = 0;

	int mismatches, waiting, checked;

	hsv2rgb_hsv_if hsv_ch();
	hsv2rgb_rgb_if rgb_ch();

	hsv_to_rgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv_in (hsv_ch),
		.rgb_out(rgb_ch)
	);

	hsv_to_rgb_checker colour_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_ch.valid),
		.hsv_ready (hsv_ch.ready),
		.hue       (hsv_ch.hue),
		.saturation(hsv_ch.saturation),
		.brightness(hsv_ch.brightness),
		.rgb_valid (rgb_ch.valid),
		.rgb_ready (rgb_ch.ready),
		.red       (rgb_ch.red),
		.green     (rgb_ch.green),
		.blue      (rgb_ch.blue),
		.mismatches(mismatches),
		.waiting   (waiting),
		.checked   (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("hsv_to_rgb_converter_tb: done, errors");
		$finish;
	end

	task automatic send_word(input logic [HUE_W-1:0] h, input logic [SAT_W-1:0] s,
			input logic [VAL_W-1:0] v);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			hsv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		hsv_ch.valid      <= 1'b1;
		hsv_ch.hue        <= h;
		hsv_ch.saturation <= s;
		hsv_ch.brightness <= v;
		@(posedge clk);
		while (!hsv_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	// output side: random stalls, one long hold-off on request
	initial begin : result_sink
		int n;
		rgb_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off) begin
				rgb_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 13);
				rgb_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rgb_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int k;
		int pick;
		logic [HUE_W-1:0] h;
		logic [SAT_W-1:0] s;
		logic [VAL_W-1:0] v;

		hsv_ch.valid = 1'b0;
		hsv_ch.hue = '0;
		hsv_ch.saturation = '0;
		hsv_ch.brightness = '0;
		// reset falls after time zero so every register sees its edge
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, sector edges, hue wrap and saturation clamp
		send_word(15'd0, 9'd0, 8'd0);
		send_word(15'd0, 9'd256, 8'd255);
		send_word(15'd32767, 9'd511, 8'd255);
		send_word(15'd23039, 9'd256, 8'd255);
		send_word(15'd23040, 9'd256, 8'd255);
		send_word(15'd23041, 9'd200, 8'd200);
		send_word(15'd3839, 9'd256, 8'd255);
		send_word(15'd3840, 9'd256, 8'd255);
		send_word(15'd7679, 9'd256, 8'd255);
		send_word(15'd7680, 9'd256, 8'd255);
		send_word(15'd11520, 9'd256, 8'd255);
		send_word(15'd15360, 9'd256, 8'd255);
		send_word(15'd19200, 9'd256, 8'd255);
		send_word(15'd1920, 9'd128, 8'd255);
		send_word(15'd5760, 9'd128, 8'd128);
		send_word(15'd9600, 9'd257, 8'd255);
		send_word(15'd13440, 9'd511, 8'd1);
		send_word(15'd17280, 9'd1, 8'd255);
		send_word(15'd21120, 9'd255, 8'd254);
		send_word(15'd16383, 9'd0, 8'd170);
		send_word(15'd21845, 9'd341, 8'd85);
		send_word(15'd10922, 9'd170, 8'd0);

		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k == HOLD_AT)
				hold_off = 1'b1;
			if (k == RANDOM_WORDS - CALM_WORDS) begin
				src_idle_en = 1'b0;
				sink_idle_en = 1'b0;
			end
			pick = $urandom_range(0, 9);
			if (pick < 2)
				h = HUE_W'($urandom_range(23040, 32767));
			else if (pick < 3)
				h = HUE_W'(int'(HUE_SECTOR) * $urandom_range(1, 6) - $urandom_range(0, 1));
			else
				h = HUE_W'($urandom_range(0, 23039));
			pick = $urandom_range(0, 9);
			if (pick < 2)
				s = SAT_W'($urandom_range(257, 511));
			else if (pick < 3)
				s = ($urandom_range(0, 1) == 0) ? SAT_W'(0) : SAT_ONE;
			else
				s = SAT_W'($urandom_range(0, 256));
			pick = $urandom_range(0, 9);
			if (pick < 1)
				v = ($urandom_range(0, 1) == 0) ? VAL_W'(0) : VAL_W'(255);
			else
				v = VAL_W'($urandom_range(0, 255));
			send_word(h, s, v);
		end
		hsv_ch.valid <= 1'b0;

		@(negedge clk);
		while (waiting != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("%0d hsv words sent (edges, wrap, clamp, random), %0d rgb words checked",
			words_sent, checked);
		$display("output held off %0d cycles once; idle bursts on both sides, then a calm tail",
			HOLD_CYCLES);
		if (mismatches == 0 && waiting == 0)
			$display("hsv_to_rgb_converter_tb: done, clean");
		else
			$display("hsv_to_rgb_converter_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_if.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_queue.sv
rtl/hsv2rgb_back.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsv2rgb_checker.sv
tb/sv/hsv_to_rgb_checker.sv
tb/sv/hsv_to_rgb_converter_tb.sv
